// ===== rtl/acp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acp_pkg: shared types and constants of the aging contact process step
// Field widths, register reset values, codes, controller/datapath
// command and status bundles, and elaboration-time lookup tables.
// ---------------------------------------------------------------------------
package acp_pkg;

   localparam int WEIGHT_W   = 16;
   localparam int AGE_W      = 8;
   localparam int CLASS_W    = 8;
   localparam int SEARCH_W   = 3;
   localparam int DRAW_W     = 32;
   localparam int SUM_W      = 32;
   localparam int COORD_IN_W = 8;
   localparam int DIR_W      = 2;
   localparam int OUTCOME_W  = 3;
   localparam int TRI_W      = 15;
   localparam int PROD_B_W   = CLASS_W + WEIGHT_W;
   localparam int PROD_S_W   = WEIGHT_W + TRI_W;
   localparam int TEST_W     = AGE_W + 2;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 16;

   localparam int GRID_SIDE_DEFAULT = 256;
   localparam int TABLE_DEPTH       = 256;

   localparam logic [WEIGHT_W-1:0] DEATH_RESET = 16'd41;
   localparam logic [WEIGHT_W-1:0] AGING_RESET = 16'd410;
   localparam logic [WEIGHT_W-1:0] BASE_RESET  = 16'd819;
   localparam logic [WEIGHT_W-1:0] STEP_RESET  = 16'd410;
   localparam logic [AGE_W-1:0]    KID_RESET   = 8'd0;
   localparam logic [AGE_W-1:0]    MAX_RESET   = 8'd5;

   typedef enum logic [2:0] {
      CSR_DEATH   = 3'd0,
      CSR_AGING   = 3'd1,
      CSR_BASE    = 3'd2,
      CSR_STEP    = 3'd3,
      CSR_KID_AGE = 3'd4,
      CSR_MAX_AGE = 3'd5
   } csr_index_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE      = 3'd0,
      OUT_DIED      = 3'd1,
      OUT_AGED      = 3'd2,
      OUT_AT_MAX    = 3'd3,
      OUT_BIRTH     = 3'd4,
      OUT_NBR_BUSY  = 3'd5,
      OUT_TOO_YOUNG = 3'd6
   } outcome_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_POS_X = 2'd0,
      DIR_POS_Y = 2'd1,
      DIR_NEG_X = 2'd2,
      DIR_NEG_Y = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      MW_NONE,
      MW_SITE_ZERO,
      MW_SITE_INC,
      MW_NBR_ONE,
      MW_CLEAR
   } mem_write_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WEIGH,
      ST_READ,
      ST_SCALE,
      ST_DECIDE,
      ST_AGING,
      ST_PROD,
      ST_CMP,
      ST_CLASS,
      ST_NBR_READ,
      ST_NBR_CHECK,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] death_weight;
      logic [WEIGHT_W-1:0] aging_weight;
      logic [WEIGHT_W-1:0] birth_base;
      logic [WEIGHT_W-1:0] birth_step;
      logic [AGE_W-1:0]    kid_age;
      logic [AGE_W-1:0]    max_age;
   } cfg_type;

   typedef struct packed {
      logic          accept;
      logic          read_site;
      logic          read_nbr;
      mem_write_type write_sel;
      logic          load_total;
      logic          load_scale;
      logic          search_init;
      logic          search_step;
      logic          set_outcome;
      outcome_type   outcome;
      logic          push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic read_op;
      logic empty;
      logic zero_total;
      logic pick_death;
      logic pick_aging;
      logic below_max;
      logic aging_birth_ok;
      logic class_birth_ok;
      logic search_last;
      logic nbr_empty;
      logic clear_last;
   } dp_status_type;

   typedef logic [COORD_IN_W-1:0] mod_table_type [TABLE_DEPTH];
   typedef logic [TRI_W-1:0]      tri_table_type [TABLE_DEPTH];

   // coordinate modulo the grid side, built by counting so no divide is needed
   function automatic mod_table_type build_mod_table(input int side);
      mod_table_type tab;
      int r;
      r = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tab[i] = COORD_IN_W'(r);
         r = r + 1;
         if (r == side) begin
            r = 0;
         end
      end
      return tab;
   endfunction

   // triangular numbers n*(n-1)/2: summed step weight of the first n classes
   function automatic tri_table_type build_tri_table();
      tri_table_type tab;
      int acc;
      acc = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tab[i] = TRI_W'(acc);
         acc = acc + i;
      end
      return tab;
   endfunction

   localparam tri_table_type TRI_TABLE = build_tri_table();

endpackage

// ===== rtl/acp_csr.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acp_csr: configuration registers
// APB-style register file holding the action weights and the age limits.
// ---------------------------------------------------------------------------
module acp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [acp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [acp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [acp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output acp_pkg::cfg_type                 cfg
);

   acp_pkg::cfg_type       cfg_ff;
   acp_pkg::cfg_type       cfg_in;
   acp_pkg::csr_index_type index;
   logic                   write_en;

   assign index      = acp_pkg::csr_index_type'(csr_paddr[acp_pkg::CSR_ADDR_W-1:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            acp_pkg::CSR_DEATH:   cfg_in.death_weight = csr_pwdata[acp_pkg::WEIGHT_W-1:0];
            acp_pkg::CSR_AGING:   cfg_in.aging_weight = csr_pwdata[acp_pkg::WEIGHT_W-1:0];
            acp_pkg::CSR_BASE:    cfg_in.birth_base   = csr_pwdata[acp_pkg::WEIGHT_W-1:0];
            acp_pkg::CSR_STEP:    cfg_in.birth_step   = csr_pwdata[acp_pkg::WEIGHT_W-1:0];
            acp_pkg::CSR_KID_AGE: cfg_in.kid_age      = csr_pwdata[acp_pkg::AGE_W-1:0];
            acp_pkg::CSR_MAX_AGE: cfg_in.max_age      = csr_pwdata[acp_pkg::AGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.death_weight <= acp_pkg::DEATH_RESET;
         cfg_ff.aging_weight <= acp_pkg::AGING_RESET;
         cfg_ff.birth_base   <= acp_pkg::BASE_RESET;
         cfg_ff.birth_step   <= acp_pkg::STEP_RESET;
         cfg_ff.kid_age      <= acp_pkg::KID_RESET;
         cfg_ff.max_age      <= acp_pkg::MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         acp_pkg::CSR_DEATH:   csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.death_weight);
         acp_pkg::CSR_AGING:   csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.aging_weight);
         acp_pkg::CSR_BASE:    csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.birth_base);
         acp_pkg::CSR_STEP:    csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.birth_step);
         acp_pkg::CSR_KID_AGE: csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.kid_age);
         acp_pkg::CSR_MAX_AGE: csr_prdata = acp_pkg::CSR_DATA_W'(cfg_ff.max_age);
         default:              csr_prdata = '0;
      endcase
   end

endmodule

// ===== rtl/acp_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acp_ctrl: sequencing state machine
// Runs the grid clearing pass, then steps each transfer through weighing,
// site read, action selection, class search and the neighbor update.
// ---------------------------------------------------------------------------
module acp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  acp_pkg::dp_status_type status,
   output acp_pkg::ctrl_cmd_type  cmd
);

   acp_pkg::ctrl_state_type state_ff;
   acp_pkg::ctrl_state_type state_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    out_free;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == acp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acp_pkg::ST_CLEAR:  if (status.clear_last) state_in = acp_pkg::ST_IDLE;
         acp_pkg::ST_IDLE:   if (req_tvalid) state_in = acp_pkg::ST_WEIGH;
         acp_pkg::ST_WEIGH:  state_in = acp_pkg::ST_READ;
         acp_pkg::ST_READ:   state_in = acp_pkg::ST_SCALE;
         acp_pkg::ST_SCALE:  state_in = acp_pkg::ST_DECIDE;
         acp_pkg::ST_DECIDE: begin
            if (status.read_op | status.empty | status.zero_total | status.pick_death) begin
               state_in = acp_pkg::ST_DONE;
            end else if (status.pick_aging) begin
               state_in = acp_pkg::ST_AGING;
            end else begin
               state_in = acp_pkg::ST_PROD;
            end
         end
         acp_pkg::ST_AGING: begin
            if (!status.below_max && status.aging_birth_ok) begin
               state_in = acp_pkg::ST_NBR_READ;
            end else begin
               state_in = acp_pkg::ST_DONE;
            end
         end
         acp_pkg::ST_PROD:   state_in = acp_pkg::ST_CMP;
         acp_pkg::ST_CMP: begin
            state_in = status.search_last ? acp_pkg::ST_CLASS : acp_pkg::ST_PROD;
         end
         acp_pkg::ST_CLASS: begin
            state_in = status.class_birth_ok ? acp_pkg::ST_NBR_READ : acp_pkg::ST_DONE;
         end
         acp_pkg::ST_NBR_READ:  state_in = acp_pkg::ST_NBR_CHECK;
         acp_pkg::ST_NBR_CHECK: state_in = acp_pkg::ST_DONE;
         acp_pkg::ST_DONE:      if (out_free) state_in = acp_pkg::ST_IDLE;
         default:               state_in = acp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.outcome = acp_pkg::OUT_NONE;
      unique case (state_ff)
         acp_pkg::ST_CLEAR:  cmd.write_sel = acp_pkg::MW_CLEAR;
         acp_pkg::ST_IDLE:   cmd.accept = req_tvalid;
         acp_pkg::ST_WEIGH:  ;
         acp_pkg::ST_READ: begin
            cmd.read_site  = 1'b1;
            cmd.load_total = 1'b1;
         end
         acp_pkg::ST_SCALE:  cmd.load_scale = 1'b1;
         acp_pkg::ST_DECIDE: begin
            if (status.read_op | status.empty | status.zero_total) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = acp_pkg::OUT_NONE;
            end else if (status.pick_death) begin
               cmd.write_sel   = acp_pkg::MW_SITE_ZERO;
               cmd.set_outcome = 1'b1;
               cmd.outcome     = acp_pkg::OUT_DIED;
            end else if (!status.pick_aging) begin
               cmd.search_init = 1'b1;
            end
         end
         acp_pkg::ST_AGING: begin
            if (status.below_max) begin
               cmd.write_sel   = acp_pkg::MW_SITE_INC;
               cmd.set_outcome = 1'b1;
               cmd.outcome     = acp_pkg::OUT_AGED;
            end else if (!status.aging_birth_ok) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = acp_pkg::OUT_AT_MAX;
            end
         end
         acp_pkg::ST_PROD:   ;
         acp_pkg::ST_CMP:    cmd.search_step = 1'b1;
         acp_pkg::ST_CLASS: begin
            if (!status.class_birth_ok) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = acp_pkg::OUT_TOO_YOUNG;
            end
         end
         acp_pkg::ST_NBR_READ: cmd.read_nbr = 1'b1;
         acp_pkg::ST_NBR_CHECK: begin
            cmd.set_outcome = 1'b1;
            if (status.nbr_empty) begin
               cmd.write_sel = acp_pkg::MW_NBR_ONE;
               cmd.outcome   = acp_pkg::OUT_BIRTH;
            end else begin
               cmd.outcome   = acp_pkg::OUT_NBR_BUSY;
            end
         end
         acp_pkg::ST_DONE:   cmd.push = out_free;
         default:            ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acp_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/acp_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acp_datapath: grid memory and arithmetic
// Holds the age grid, the weight products shared by the total and the
// class search, the draw scaling multiplier and the result registers.
// ---------------------------------------------------------------------------
module acp_datapath #(
   parameter int GRID_SIDE = acp_pkg::GRID_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  acp_pkg::cfg_type                  cfg,
   input  acp_pkg::ctrl_cmd_type             cmd,
   output acp_pkg::dp_status_type            status,
   input  logic                              req_opcode,
   input  logic [acp_pkg::COORD_IN_W-1:0]    req_site_x,
   input  logic [acp_pkg::COORD_IN_W-1:0]    req_site_y,
   input  logic [acp_pkg::DRAW_W-1:0]        req_draw,
   input  logic [acp_pkg::DIR_W-1:0]         req_direction,
   output logic [acp_pkg::AGE_W-1:0]         rsp_cell_age,
   output logic [acp_pkg::OUTCOME_W-1:0]     rsp_outcome
);

   localparam int CW     = $clog2(GRID_SIDE);
   localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int CENTRE = (GRID_SIDE / 2) * GRID_SIDE + GRID_SIDE / 2;
   localparam int SW     = acp_pkg::SUM_W;
   localparam int AGW    = acp_pkg::AGE_W;
   localparam int NW     = acp_pkg::CLASS_W;
   localparam int TW     = acp_pkg::TEST_W;
   localparam logic [acp_pkg::SEARCH_W-1:0] SEARCH_TOP = acp_pkg::SEARCH_W'(NW - 1);
   localparam acp_pkg::mod_table_type MOD_TABLE = acp_pkg::build_mod_table(GRID_SIDE);

   logic [AGW-1:0] grid_mem [DEPTH];

   // captured transfer
   logic                  op_ff;
   logic [CW-1:0]         x_ff;
   logic [CW-1:0]         y_ff;
   logic [SW-1:0]         draw_ff;
   acp_pkg::dir_type      dir_ff;

   // addressing
   logic [CW-1:0]         nbr_x_ff;
   logic [CW-1:0]         nbr_y_ff;
   logic [CW-1:0]         nbr_x_in;
   logic [CW-1:0]         nbr_y_in;
   logic [AW-1:0]         addr_ff;
   logic [AW-1:0]         nbr_addr_ff;
   logic [AW-1:0]         clr_cnt_ff;

   // memory port
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [AGW-1:0]        mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [AGW-1:0]        rdata_ff;

   // weights and search
   logic [NW-1:0]                    classes;
   logic [NW-1:0]                    n_ff;
   logic [NW-1:0]                    res_ff;
   logic [NW-1:0]                    res_in;
   logic [acp_pkg::SEARCH_W-1:0]     bit_ff;
   logic [acp_pkg::PROD_B_W-1:0]     prod_b_ff;
   logic [acp_pkg::PROD_S_W-1:0]     prod_s_ff;
   logic [SW-1:0]                    cum;
   logic [SW-1:0]                    dth_agg;
   logic [SW-1:0]                    total_ff;
   logic [2*SW-1:0]                  scaled;
   logic [SW-1:0]                    t_ff;
   logic [SW-1:0]                    u_ff;
   logic                             take;
   logic [AGW-1:0]                   age_ff;

   // result
   logic [AGW-1:0]        pend_age_ff;
   logic [AGW-1:0]        pend_age_in;
   acp_pkg::outcome_type  pend_outcome_ff;
   logic [AGW-1:0]        out_age_ff;
   acp_pkg::outcome_type  out_outcome_ff;

   assign classes = (cfg.max_age > cfg.kid_age) ? (cfg.max_age - cfg.kid_age) : '0;
   assign cum     = SW'(prod_b_ff) + SW'(prod_s_ff);
   assign dth_agg = SW'(cfg.death_weight) + SW'(cfg.aging_weight);
   assign scaled  = (2*SW)'(draw_ff) * (2*SW)'(total_ff);
   assign take    = (n_ff < classes) && (cum <= u_ff);
   assign res_in  = take ? n_ff : res_ff;

   // transfer capture; coordinates are reduced modulo the side here
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_opcode;
         x_ff    <= CW'(MOD_TABLE[req_site_x]);
         y_ff    <= CW'(MOD_TABLE[req_site_y]);
         draw_ff <= req_draw;
         dir_ff  <= acp_pkg::dir_type'(req_direction);
      end
   end

   always_comb begin
      nbr_x_in = x_ff;
      nbr_y_in = y_ff;
      case (dir_ff)
         acp_pkg::DIR_POS_X: nbr_x_in = (x_ff == CW'(GRID_SIDE - 1)) ? '0 : x_ff + CW'(1);
         acp_pkg::DIR_POS_Y: nbr_y_in = (y_ff == CW'(GRID_SIDE - 1)) ? '0 : y_ff + CW'(1);
         acp_pkg::DIR_NEG_X: nbr_x_in = (x_ff == '0) ? CW'(GRID_SIDE - 1) : x_ff - CW'(1);
         acp_pkg::DIR_NEG_Y: nbr_y_in = (y_ff == '0) ? CW'(GRID_SIDE - 1) : y_ff - CW'(1);
         default: ;
      endcase
   end

   // coordinates hold for the whole item, so the addresses follow freely
   always_ff @(posedge clock) begin
      nbr_x_ff    <= nbr_x_in;
      nbr_y_ff    <= nbr_y_in;
      addr_ff     <= AW'(AW'(y_ff) * AW'(GRID_SIDE) + AW'(x_ff));
      nbr_addr_ff <= AW'(AW'(nbr_y_ff) * AW'(GRID_SIDE) + AW'(nbr_x_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.write_sel == acp_pkg::MW_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   always_comb begin
      mem_we    = 1'b1;
      mem_waddr = addr_ff;
      mem_wdata = '0;
      case (cmd.write_sel)
         acp_pkg::MW_SITE_ZERO: mem_wdata = '0;
         acp_pkg::MW_SITE_INC:  mem_wdata = age_ff + AGW'(1);
         acp_pkg::MW_NBR_ONE: begin
            mem_waddr = nbr_addr_ff;
            mem_wdata = AGW'(1);
         end
         acp_pkg::MW_CLEAR: begin
            mem_waddr = clr_cnt_ff;
            mem_wdata = (clr_cnt_ff == AW'(CENTRE)) ? AGW'(1) : '0;
         end
         default: mem_we = 1'b0;
      endcase
   end

   assign mem_re    = cmd.read_site | cmd.read_nbr;
   assign mem_raddr = cmd.read_nbr ? nbr_addr_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= grid_mem[mem_raddr];
      end
   end

   // one product pair serves both the total weight and each search probe
   always_ff @(posedge clock) begin
      prod_b_ff <= acp_pkg::PROD_B_W'(n_ff) * acp_pkg::PROD_B_W'(cfg.birth_base);
      prod_s_ff <= acp_pkg::PROD_S_W'(cfg.birth_step) *
                   acp_pkg::PROD_S_W'(acp_pkg::TRI_TABLE[n_ff]);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         n_ff <= classes;
      end else if (cmd.search_init) begin
         n_ff <= NW'(1) << SEARCH_TOP;
      end else if (cmd.search_step && bit_ff != '0) begin
         n_ff <= res_in | (NW'(1) << (bit_ff - acp_pkg::SEARCH_W'(1)));
      end
   end

   // binary search for the largest class count whose weight stays at or below u
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         res_ff <= '0;
         bit_ff <= SEARCH_TOP;
         u_ff   <= t_ff - dth_agg;
      end else if (cmd.search_step) begin
         res_ff <= res_in;
         if (bit_ff != '0) begin
            bit_ff <= bit_ff - acp_pkg::SEARCH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_total) begin
         total_ff <= dth_agg + cum;
      end
      if (cmd.load_scale) begin
         t_ff   <= scaled[2*SW-1:SW];
         age_ff <= rdata_ff;
      end
   end

   always_comb begin
      case (cmd.outcome)
         acp_pkg::OUT_DIED: pend_age_in = '0;
         acp_pkg::OUT_AGED: pend_age_in = age_ff + AGW'(1);
         default:           pend_age_in = age_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_outcome) begin
         pend_age_ff     <= pend_age_in;
         pend_outcome_ff <= cmd.outcome;
      end
      if (cmd.push) begin
         out_age_ff     <= pend_age_ff;
         out_outcome_ff <= pend_outcome_ff;
      end
   end

   assign rsp_cell_age = out_age_ff;
   assign rsp_outcome  = out_outcome_ff;

   assign status.read_op        = op_ff;
   assign status.empty          = (age_ff == '0);
   assign status.zero_total     = (total_ff == '0);
   assign status.pick_death     = (t_ff < SW'(cfg.death_weight));
   assign status.pick_aging     = (t_ff < dth_agg);
   assign status.below_max      = (age_ff < cfg.max_age);
   assign status.aging_birth_ok = (cfg.kid_age <= age_ff);
   assign status.class_birth_ok = (TW'(res_ff) + TW'(cfg.kid_age) + TW'(1) <= TW'(age_ff));
   assign status.search_last    = (bit_ff == '0);
   assign status.nbr_empty      = (rdata_ff == '0);
   assign status.clear_last     = (clr_cnt_ff == AW'(DEPTH - 1));

endmodule

// ===== rtl/aging_contact_process_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aging_contact_process_step: one site update of an aging contact process
// Toroidal grid of cell ages updated by death, aging and neighbor birth.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one site update or read per transfer (req_tuser is the
//   opcode); rsp_* returns exactly one result per request, in order.
//   csr_* is an APB-style register port for the weights and age limits;
//   write it only while no request is in flight.
// Sequencing:
//   One request at a time. Reads, empty sites, death and zero total take
//   the shortest path; aging, a birth tried from maximum age and a birth
//   class draw take longer, in that order. The long path is the 8-step
//   binary search over the birth classes, run on the shared weight
//   multipliers; the grid memory has one read port and one write port.
// Reset:
//   After reset the grid memory is swept one entry a cycle, all GRID_SIDE^2
//   entries, writing zero everywhere and one at the center; req_tready
//   stays low until the sweep ends. Registers take their defaults at once.
// Stall:
//   The result waits in an output register; the next request is still
//   taken and held finished until rsp_tready frees the register.
// ---------------------------------------------------------------------------
module aging_contact_process_step #(
   parameter int GRID_SIDE = acp_pkg::GRID_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // site_x[7:0], site_y[15:8], draw[47:16], direction[49:48], zero pad
   input  logic [acp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // cell_age[7:0], outcome[10:8], zero pad
   output logic [acp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [acp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [acp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [acp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   acp_pkg::cfg_type                     cfg;
   acp_pkg::ctrl_cmd_type                cmd;
   acp_pkg::dp_status_type               status;
   logic [acp_pkg::AGE_W-1:0]            rsp_cell_age;
   logic [acp_pkg::OUTCOME_W-1:0]        rsp_outcome;

   assign rsp_tdata = acp_pkg::RSP_TDATA_W'({rsp_outcome, rsp_cell_age});

   acp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   acp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   acp_datapath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_opcode    (req_tuser),
      .req_site_x    (req_tdata[7:0]),
      .req_site_y    (req_tdata[15:8]),
      .req_draw      (req_tdata[47:16]),
      .req_direction (req_tdata[49:48]),
      .rsp_cell_age  (rsp_cell_age),
      .rsp_outcome   (rsp_outcome)
   );

endmodule

// ===== rtl/acp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acp_checker: port-level checks
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
module acp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [acp_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // clearing pass keeps the input closed and no result is pending
   assert property (@(posedge clock) reset |=> !req_tready && !rsp_tvalid)
      else $error("request accepted or result shown right after reset");

   // one request in flight: input closes after every transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request port stayed open after a transfer");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // a cell that died reads back empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10:8] == acp_pkg::OUT_DIED |-> rsp_tdata[7:0] == '0)
      else $error("death result with nonzero age");

endmodule

bind aging_contact_process_step acp_checker u_acp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
